// File: rtl/core/asrs_pkg.sv
package asrs_pkg;

  localparam int CLK_W    = 28;
  localparam int RATE_W   = 24;
  localparam int CYC_W    = 10;
  localparam int PROD_W   = CYC_W + RATE_W;
  localparam int LG_W     = 4;
  localparam int SH_W     = 3;
  localparam int IDX_W    = 3;
  localparam int PC_W     = 4;
  localparam int TABLE_SIZE = 8;

  localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd80000000;

  localparam logic [CYC_W-1:0] CYCLE_TABLE [TABLE_SIZE] = '{
    10'd15, 10'd19, 10'd25, 10'd37, 10'd60, 10'd105, 10'd260, 10'd653
  };

  // program step addresses
  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL      = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIVQ     = 4'd2;
  localparam logic [PC_W-1:0] STEP_WAITQ    = 4'd3;
  localparam logic [PC_W-1:0] STEP_RATIO    = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIVS     = 4'd5;
  localparam logic [PC_W-1:0] STEP_WAITS    = 4'd6;
  localparam logic [PC_W-1:0] STEP_COMPARE  = 4'd7;
  localparam logic [PC_W-1:0] STEP_OUT_WAIT = 4'd8;
  localparam logic [PC_W-1:0] STEP_OUT_LOAD = 4'd9;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ZERO_RATE,
    COND_DIV_BUSY,
    COND_MORE,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            clr_best;
    logic            ld_prod;
    logic            div_q;
    logic            div_s;
    logic            ld_ratio;
    logic            upd_best;
    logic            ld_out;
  } uword_t;

  function automatic logic [LG_W-1:0] pick_lg(input logic [CLK_W-1:0] q);
    logic [LG_W-1:0] lg;
    if      (q > 28'd128) lg = 4'd8;
    else if (q > 28'd64)  lg = 4'd7;
    else if (q > 28'd32)  lg = 4'd6;
    else if (q > 28'd16)  lg = 4'd5;
    else if (q > 28'd8)   lg = 4'd4;
    else if (q > 28'd4)   lg = 4'd3;
    else if (q > 28'd2)   lg = 4'd2;
    else if (q > 28'd0)   lg = 4'd1;
    else                  lg = 4'd0;
    return lg;
  endfunction

  function automatic logic [SH_W-1:0] pick_sh(input logic [CLK_W-1:0] q);
    logic [SH_W-1:0] sh;
    if      (q > 28'd128) sh = 3'd4;
    else if (q > 28'd64)  sh = 3'd3;
    else if (q > 28'd32)  sh = 3'd2;
    else if (q > 28'd16)  sh = 3'd1;
    else                  sh = 3'd0;
    return sh;
  endfunction

endpackage

// File: rtl/core/asrs_ucode_rom.sv
module asrs_ucode_rom
  import asrs_pkg::*;
(
  input  logic [PC_W-1:0] pc,
  output uword_t          uword
);

  always_comb begin
    uword = '{cond: COND_ALWAYS, target: STEP_IDLE, default: 1'b0};
    case (pc)
      STEP_IDLE: begin
        uword.cond     = COND_NO_INPUT;
        uword.target   = STEP_IDLE;
        uword.clr_best = 1'b1;
      end
      STEP_MUL: begin
        uword.cond    = COND_ZERO_RATE;
        uword.target  = STEP_OUT_WAIT;
        uword.ld_prod = 1'b1;
      end
      STEP_DIVQ: begin
        uword.cond  = COND_NEVER;
        uword.div_q = 1'b1;
      end
      STEP_WAITQ: begin
        uword.cond   = COND_DIV_BUSY;
        uword.target = STEP_WAITQ;
      end
      STEP_RATIO: begin
        uword.cond     = COND_NEVER;
        uword.ld_ratio = 1'b1;
      end
      STEP_DIVS: begin
        uword.cond  = COND_NEVER;
        uword.div_s = 1'b1;
      end
      STEP_WAITS: begin
        uword.cond   = COND_DIV_BUSY;
        uword.target = STEP_WAITS;
      end
      STEP_COMPARE: begin
        uword.cond     = COND_MORE;
        uword.target   = STEP_MUL;
        uword.upd_best = 1'b1;
      end
      STEP_OUT_WAIT: begin
        uword.cond   = COND_OUT_FULL;
        uword.target = STEP_OUT_WAIT;
      end
      STEP_OUT_LOAD: begin
        uword.cond   = COND_ALWAYS;
        uword.target = STEP_IDLE;
        uword.ld_out = 1'b1;
      end
      default: begin
        uword.cond   = COND_ALWAYS;
        uword.target = STEP_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/asrs_divider.sv
module asrs_divider
  import asrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [PROD_W-1:0] divisor,
  output logic              busy,
  output logic [CLK_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(CLK_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsr;
  logic [PROD_W:0]   trial;
  logic [PROD_W:0]   diff;
  logic              ge;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    trial = {rem, quotient[CLK_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(CLK_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
      quotient <= {quotient[CLK_W-2:0], ge};
    end
  end

endmodule

// File: rtl/core/adc_sample_rate_solver.sv
// channel   direction  fields
// cfg       in         cfg_data (core clock in hertz)
// in        in         sample_rate
// out       out        time_index, oversample_enable, ratio_log2, right_shift,
//                      achieved_rate, zero_rate_error
//
// a candidate waits twice on the shared bit-serial divider (28-bit quotient)
// plus five control steps; up to eight candidates are tried for each
// accepted request
// a zero request skips the candidate search
// reset is synchronous; the clock register returns to 80 MHz
// a new request is taken only while the sequencer idles; a finished
// transaction waits in the output register while the next one is solved,
// and the sequencer stalls before loading while that transaction is unaccepted
module adc_sample_rate_solver
  import asrs_pkg::*;
#(
  parameter int NUM_CYCLE_OPTIONS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RATE_W-1:0] sample_rate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  time_index,
  output logic              oversample_enable,
  output logic [LG_W-1:0]   ratio_log2,
  output logic [SH_W-1:0]   right_shift,
  output logic [CLK_W-1:0]  achieved_rate,
  output logic              zero_rate_error
);

  localparam int LastIdx =
    ((NUM_CYCLE_OPTIONS > TABLE_SIZE) ? TABLE_SIZE : NUM_CYCLE_OPTIONS) - 1;

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  uword_t            uw;
  logic              take;

  logic [CLK_W-1:0]  core_clock;
  logic [RATE_W-1:0] rate;
  logic [IDX_W-1:0]  idx;
  logic [CYC_W-1:0]  cyc;
  logic [PROD_W-1:0] prod;
  logic [LG_W-1:0]   lg;
  logic [SH_W-1:0]   sh;
  logic              have;
  logic [CLK_W-1:0]  best_diff;
  logic [IDX_W-1:0]  best_idx;
  logic [LG_W-1:0]   best_lg;
  logic [SH_W-1:0]   best_sh;
  logic [CLK_W-1:0]  best_speed;

  logic              div_start;
  logic [PROD_W-1:0] div_divisor;
  logic              div_busy;
  logic [CLK_W-1:0]  div_quo;
  logic [CLK_W-1:0]  rate_ext;
  logic [CLK_W-1:0]  diff;
  logic              more;

  asrs_ucode_rom u_rom (
    .pc    (pc),
    .uword (uw)
  );

  asrs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (core_clock),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (pc == STEP_IDLE);
  assign cyc       = CYCLE_TABLE[idx];
  assign more      = (idx != IDX_W'(LastIdx));
  assign div_start = uw.div_q | uw.div_s;
  // speed divisor is cycles times ratio
  assign div_divisor = uw.div_s ? (PROD_W'(cyc) << lg) : prod;
  assign rate_ext  = CLK_W'(rate);
  assign diff      = (div_quo > rate_ext) ? (div_quo - rate_ext) : (rate_ext - div_quo);

  always_comb begin
    case (uw.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !in_valid;
      COND_ZERO_RATE: take = (rate == '0);
      COND_DIV_BUSY:  take = div_busy;
      COND_MORE:      take = more;
      COND_OUT_FULL:  take = out_valid && !out_ready;
      default:        take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= STEP_IDLE;
      core_clock <= CLOCK_RESET;
      out_valid  <= 1'b0;
      idx        <= '0;
      have       <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) core_clock <= cfg_data;
      if (uw.clr_best) begin
        idx  <= '0;
        have <= 1'b0;
      end
      if (uw.upd_best) begin
        have <= 1'b1;
        if (more) idx <= idx + 1'b1;
      end
      if (uw.ld_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) rate <= sample_rate;
    if (uw.ld_prod) prod <= PROD_W'(rate) * PROD_W'(cyc);
    if (uw.ld_ratio) begin
      lg <= pick_lg(div_quo);
      sh <= pick_sh(div_quo);
    end
    // strict compare keeps the earlier candidate on a tie
    if (uw.upd_best && (!have || diff < best_diff)) begin
      best_diff  <= diff;
      best_idx   <= idx;
      best_lg    <= lg;
      best_sh    <= sh;
      best_speed <= div_quo;
    end
    if (uw.ld_out) begin
      if (rate == '0) begin
        time_index        <= '0;
        oversample_enable <= 1'b0;
        ratio_log2        <= '0;
        right_shift       <= '0;
        achieved_rate     <= '0;
        zero_rate_error   <= 1'b1;
      end else begin
        time_index        <= best_idx;
        oversample_enable <= (best_lg != '0);
        ratio_log2        <= best_lg;
        right_shift       <= best_sh;
        achieved_rate     <= best_speed;
        zero_rate_error   <= 1'b0;
      end
    end
  end

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_OUT_LOAD) |-> !out_valid)
    else $error("output register overwritten while full");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (pc == STEP_WAITQ || pc == STEP_WAITS))
    else $error("divider busy outside a wait step");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_rate_error) |-> (achieved_rate == '0 && ratio_log2 == '0))
    else $error("zero request with nonzero result");

  a_enable_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_rate_error) |-> (oversample_enable == (ratio_log2 != '0)))
    else $error("oversample enable disagrees with ratio");

  a_shift_ratio: assert property (@(posedge clk) disable iff (rst)
    (out_valid && right_shift != '0) |-> (ratio_log2 >= 4'd5))
    else $error("shift without a large enough ratio");

endmodule
